>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the lidar sector obstacle avoid unit.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> src/lsoa_pkg.sv
// Shared types, codes and helpers for the lidar sector obstacle avoid unit.
// No dependencies.
package lsoa_pkg;

   localparam logic [16:0] NO_READING = 17'h10000;
   localparam logic [16:0] STOP_TURN  = 17'd300;
   localparam logic [16:0] SLOW_TURN  = 17'd100;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   typedef logic [1:0] action_type;
   localparam action_type ACT_NONE = 2'd0;
   localparam action_type ACT_SLOW = 2'd1;
   localparam action_type ACT_STOP = 2'd2;

   typedef logic [2:0] reg_index_type;
   localparam reg_index_type REG_FRONT_FIRST = 3'd0;
   localparam reg_index_type REG_FRONT_LAST  = 3'd1;
   localparam reg_index_type REG_LEFT_FIRST  = 3'd2;
   localparam reg_index_type REG_LEFT_LAST   = 3'd3;
   localparam reg_index_type REG_RIGHT_FIRST = 3'd4;
   localparam reg_index_type REG_RIGHT_LAST  = 3'd5;
   localparam reg_index_type REG_STOP_DIST   = 3'd6;
   localparam reg_index_type REG_SLOW_DIST   = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic [11:0] front_first;
      logic [11:0] front_last;
      logic [11:0] left_first;
      logic [11:0] left_last;
      logic [11:0] right_first;
      logic [11:0] right_last;
      logic [15:0] stop_distance;
      logic [15:0] slow_distance;
   } cfg_type;

   typedef struct packed {
      logic take_sample;
      logic take_tick;
      logic mul_en;
      logic div_start;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic slow;
      logic div_done;
      logic out_free;
   } status_type;

   // Inclusive sector test; bounds clamp to the last legal index, reversed bounds swap.
   function automatic logic sector_hit(input logic [11:0] idx, input logic [11:0] a,
                                       input logic [11:0] b, input logic [16:0] max_last);
      logic [11:0] lo;
      logic [11:0] hi;
      logic [11:0] t;
      lo = ({5'd0, a} > max_last) ? max_last[11:0] : a;
      hi = ({5'd0, b} > max_last) ? max_last[11:0] : b;
      if (hi < lo) begin
         t  = lo;
         lo = hi;
         hi = t;
      end
      return (idx >= lo) && (idx <= hi);
   endfunction

endpackage

>>> src/lsoa_csr.sv
// Configuration register file with an APB-style access port.
// Depends on lsoa_pkg.
module lsoa_csr import lsoa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.front_first   <= '0;
         cfg_ff.front_last    <= '0;
         cfg_ff.left_first    <= '0;
         cfg_ff.left_last     <= '0;
         cfg_ff.right_first   <= '0;
         cfg_ff.right_last    <= '0;
         cfg_ff.stop_distance <= 16'd1200;
         cfg_ff.slow_distance <= 16'd2500;
      end else if (wr_en) begin
         case (index)
            REG_FRONT_FIRST: cfg_ff.front_first   <= csr_pwdata[11:0];
            REG_FRONT_LAST:  cfg_ff.front_last    <= csr_pwdata[11:0];
            REG_LEFT_FIRST:  cfg_ff.left_first    <= csr_pwdata[11:0];
            REG_LEFT_LAST:   cfg_ff.left_last     <= csr_pwdata[11:0];
            REG_RIGHT_FIRST: cfg_ff.right_first   <= csr_pwdata[11:0];
            REG_RIGHT_LAST:  cfg_ff.right_last    <= csr_pwdata[11:0];
            REG_STOP_DIST:   cfg_ff.stop_distance <= csr_pwdata[15:0];
            REG_SLOW_DIST:   cfg_ff.slow_distance <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_FRONT_FIRST: csr_prdata = {20'd0, cfg_ff.front_first};
         REG_FRONT_LAST:  csr_prdata = {20'd0, cfg_ff.front_last};
         REG_LEFT_FIRST:  csr_prdata = {20'd0, cfg_ff.left_first};
         REG_LEFT_LAST:   csr_prdata = {20'd0, cfg_ff.left_last};
         REG_RIGHT_FIRST: csr_prdata = {20'd0, cfg_ff.right_first};
         REG_RIGHT_LAST:  csr_prdata = {20'd0, cfg_ff.right_last};
         REG_STOP_DIST:   csr_prdata = {16'd0, cfg_ff.stop_distance};
         REG_SLOW_DIST:   csr_prdata = {16'd0, cfg_ff.slow_distance};
         default:         csr_prdata = '0;
      endcase
   end

endmodule

>>> src/lsoa_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies; no types used beyond plain logic.
module lsoa_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff,  busy_in;
   logic        done_ff,  done_in;
   logic [4:0]  cnt_ff,   cnt_in;
   logic [15:0] rem_ff,   rem_in;
   logic [31:0] quo_ff,   quo_in;
   logic [16:0] rem_shift;
   logic [16:0] rem_diff;

   assign rem_shift = {rem_ff, quo_ff[31]};
   assign rem_diff  = rem_shift - {1'b0, divisor};
   assign done      = done_ff;
   assign quotient  = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, divisor}) begin
            rem_in = rem_diff[15:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_shift[15:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

>>> src/lsoa_dp.sv
// Datapath: sector minima, tick decision, speed scaling and the result register.
// Depends on lsoa_pkg and lsoa_div.
module lsoa_dp import lsoa_pkg::*; #(
   parameter int MAX_SAMPLES  = 4096,
   parameter int RANGE_MIN_MM = 100,
   parameter int RANGE_MAX_MM = 30000
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [11:0]        req_sample_index,
   input  logic [15:0]        req_range_mm,
   input  logic               req_range_finite,
   input  logic               req_scan_end,
   input  logic signed [15:0] req_speed_in,
   input  logic signed [15:0] req_turn_in,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [1:0]         rsp_action,
   output logic signed [15:0] rsp_speed_out,
   output logic signed [15:0] rsp_turn_out
);

   localparam logic [16:0] IDX_LIMIT = 17'(MAX_SAMPLES);
   localparam logic [16:0] MAX_LAST  = 17'(MAX_SAMPLES - 1);
   localparam logic [15:0] RMIN      = 16'(RANGE_MIN_MM);
   localparam logic [15:0] RMAX      = 16'(RANGE_MAX_MM);

   logic [16:0] run_ff [3];
   logic [16:0] com_ff [3];
   logic [16:0] run_upd [3];
   logic [2:0]  hit;
   logic        sample_ok;

   action_type  act_ff, act_in;
   logic [15:0] turn_ff, turn_in;
   logic [15:0] hold_ff;
   logic [15:0] mag_ff;
   logic        neg_ff;
   logic [15:0] num_ff, den_ff;
   logic [31:0] prod_ff;

   logic        rsp_valid_ff;
   action_type  rsp_action_ff;
   logic [15:0] rsp_speed_ff, rsp_turn_ff;

   logic        has_l, has_r, has_f, go_left, is_stop, is_slow;
   logic [16:0] step;
   logic [16:0] turn_sum;
   logic [15:0] speed_neg;
   logic        div_done;
   logic [31:0] quotient;
   logic [15:0] q16;
   logic [15:0] speed_res;

   // Sample path: qualify the range, test the three sectors, fold into the minima.
   assign sample_ok = req_range_finite && ({5'd0, req_sample_index} < IDX_LIMIT) &&
                      (req_range_mm >= RMIN) && (req_range_mm <= RMAX);
   assign hit[0] = sector_hit(req_sample_index, cfg.front_first, cfg.front_last, MAX_LAST);
   assign hit[1] = sector_hit(req_sample_index, cfg.left_first, cfg.left_last, MAX_LAST);
   assign hit[2] = sector_hit(req_sample_index, cfg.right_first, cfg.right_last, MAX_LAST);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (sample_ok && hit[i] && ({1'b0, req_range_mm} < run_ff[i])) begin
            run_upd[i] = {1'b0, req_range_mm};
         end else begin
            run_upd[i] = run_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            run_ff[i] <= NO_READING;
            com_ff[i] <= NO_READING;
         end
      end else if (cmd.take_sample) begin
         for (int i = 0; i < 3; i++) begin
            if (req_scan_end) begin
               com_ff[i] <= run_upd[i];
               run_ff[i] <= NO_READING;
            end else begin
               run_ff[i] <= run_upd[i];
            end
         end
      end
   end

   // Tick decision from the committed minima.
   assign has_f   = !com_ff[0][16];
   assign has_l   = !com_ff[1][16];
   assign has_r   = !com_ff[2][16];
   assign go_left = (has_l && has_r) ? (com_ff[1] > com_ff[2]) : has_l;
   assign is_stop = has_f && (com_ff[0] < {1'b0, cfg.stop_distance});
   assign is_slow = has_f && !is_stop && (com_ff[0] < {1'b0, cfg.slow_distance});

   always_comb begin
      act_in = ACT_NONE;
      step   = '0;
      if (is_stop) begin
         act_in = ACT_STOP;
         if (has_l || has_r) begin
            step = go_left ? STOP_TURN : 17'(-STOP_TURN);
         end
      end else if (is_slow) begin
         act_in = ACT_SLOW;
         if (has_l && has_r) begin
            step = go_left ? SLOW_TURN : 17'(-SLOW_TURN);
         end
      end
      turn_sum = {req_turn_in[15], req_turn_in} + step;
      // Saturate when the carry out disagrees with the sign.
      if (turn_sum[16] != turn_sum[15]) begin
         turn_in = turn_sum[16] ? 16'h8000 : 16'h7FFF;
      end else begin
         turn_in = turn_sum[15:0];
      end
   end

   assign speed_neg = 16'(-req_speed_in);

   always_ff @(posedge clock) begin
      if (cmd.take_tick) begin
         act_ff  <= act_in;
         turn_ff <= turn_in;
         hold_ff <= is_stop ? 16'd0 : req_speed_in;
         mag_ff  <= req_speed_in[15] ? speed_neg : req_speed_in;
         neg_ff  <= req_speed_in[15];
         num_ff  <= com_ff[0][15:0] - cfg.stop_distance;
         den_ff  <= cfg.slow_distance - cfg.stop_distance;
      end
      if (cmd.mul_en) begin
         prod_ff <= {16'd0, mag_ff} * {16'd0, num_ff};
      end
   end

   lsoa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // The scaled magnitude stays below |speed_in|, so sixteen bits hold it.
   assign q16       = quotient[15:0];
   assign speed_res = (act_ff == ACT_SLOW) ? (neg_ff ? 16'(-q16) : q16) : hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_action_ff <= act_ff;
         rsp_speed_ff  <= speed_res;
         rsp_turn_ff   <= turn_ff;
      end
   end

   assign status.slow     = (act_ff == ACT_SLOW);
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_action    = rsp_action_ff;
   assign rsp_speed_out = rsp_speed_ff;
   assign rsp_turn_out  = rsp_turn_ff;

endmodule

>>> src/lsoa_ctrl.sv
// Controller state machine: request intake, multiply, divide and result load.
// Depends on lsoa_pkg.
module lsoa_ctrl import lsoa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_kind,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd,
   output state_type  state
);

   state_type state_ff, state_in;

   assign state = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_TICK) begin
                  cmd.take_tick = 1'b1;
                  state_in      = ST_MUL;
               end else begin
                  cmd.take_sample = 1'b1;
               end
            end
         end
         ST_MUL: begin
            // Only a slowed tick needs the scaling; others go straight to the output.
            if (status.slow) begin
               cmd.mul_en = 1'b1;
               state_in   = ST_DIV_GO;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/lidar_sector_obstacle_avoid_unit.sv
// Lidar sector obstacle avoid unit, top level.
// Range samples: accepted one per cycle while intake is not stalled, no result; minima update at the accept edge.
// Control ticks: after the multiply state the result is loaded when not slowed; when slowed,
// the divide-start and divide-wait states for the bit-serial divider come before the load;
// intake stalls until the result is loaded, and the load waits while rsp_stall holds a result.
// Synchronous active-high reset: minima read as no reading, distances 1200/2500 mm.
`include "assert_macros.svh"
module lidar_sector_obstacle_avoid_unit import lsoa_pkg::*; #(
   parameter int MAX_SAMPLES  = 4096,
   parameter int RANGE_MIN_MM = 100,
   parameter int RANGE_MAX_MM = 30000
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [11:0]        req_sample_index,
   input  logic [15:0]        req_range_mm,
   input  logic               req_range_finite,
   input  logic               req_scan_end,
   input  logic signed [15:0] req_speed_in,
   input  logic signed [15:0] req_turn_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_action,
   output logic signed [15:0] rsp_speed_out,
   output logic signed [15:0] rsp_turn_out,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   state_type  state;
   logic       tick_accept;

   lsoa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lsoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   lsoa_dp #(
      .MAX_SAMPLES  (MAX_SAMPLES),
      .RANGE_MIN_MM (RANGE_MIN_MM),
      .RANGE_MAX_MM (RANGE_MAX_MM)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_sample_index (req_sample_index),
      .req_range_mm     (req_range_mm),
      .req_range_finite (req_range_finite),
      .req_scan_end     (req_scan_end),
      .req_speed_in     (req_speed_in),
      .req_turn_in      (req_turn_in),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_action       (rsp_action),
      .rsp_speed_out    (rsp_speed_out),
      .rsp_turn_out     (rsp_turn_out)
   );

   assign tick_accept = req_valid && !req_stall && (req_kind == KIND_TICK);

   `ASSERT_NEXT(a_tick_blocks_intake, clock, reset, tick_accept, req_stall)
   `ASSERT_SAME(a_div_done_in_wait, clock, reset, status.div_done, state == ST_DIV_WAIT)
   `ASSERT_NEXT(a_load_shows_result, clock, reset, cmd.load_out, rsp_valid)
   `ASSERT_SAME(a_load_only_when_free, clock, reset, cmd.load_out, !rsp_valid || !rsp_stall)

endmodule
